>>> hdl/cfc_pkg.sv
// Package: word types, status and command codes, helper functions for the frame checker.
`timescale 1ns / 1ps
package cfc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       flush;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  frame_status;
        logic [2:0]  command;
        logic [7:0]  value_0;
        logic [7:0]  value_1;
        logic [7:0]  value_2;
        logic [7:0]  value_3;
        logic [6:0]  value_4;
        logic [6:0]  value_5;
        logic [15:0] received_crc;
        logic        settings_complete;
    } out_word_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LENGTH  = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_TAG     = 3'd3;
    localparam logic [2:0] ST_DATA    = 3'd4;
    localparam logic [2:0] ST_HEX     = 3'd5;
    localparam logic [2:0] ST_CRC     = 3'd6;
    localparam logic [2:0] ST_UNKNOWN = 3'd7;

    localparam logic [2:0] CMD_IP    = 3'd0;
    localparam logic [2:0] CMD_MASK  = 3'd1;
    localparam logic [2:0] CMD_GW    = 3'd2;
    localparam logic [2:0] CMD_NTP   = 3'd3;
    localparam logic [2:0] CMD_DATE  = 3'd4;
    localparam logic [2:0] CMD_OTHER = 3'd5;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam logic [4:0] FRAME_LEN = 5'd23;
    localparam logic [4:0] OVER_LEN  = 5'd24;
    localparam int         NDIGITS   = 12;

    // frame summary handed from the front part to the back part
    typedef struct packed {
        logic [2:0]   status;
        logic [2:0]   command;
        logic [15:0]  rcrc;
        logic [47:0]  digits;   // 12 BCD digits, entry 0 in [3:0]
    } frame_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

endpackage

>>> hdl/cfc_front.sv
// Front part: accepts bytes, tracks position, CRC, hex and faults, emits frame summaries.
`timescale 1ns / 1ps
module cfc_front
    import cfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_word_t in_word,
    input  logic     in_valid,
    output logic     in_stall,
    output frame_t   frm,
    output logic     frm_valid,
    input  logic     frm_stall
);

    logic [4:0]  count_reg;
    logic [15:0] crc_reg;
    logic [15:0] hex_reg;
    logic [2:0]  err_reg;
    logic [7:0]  letter_reg;
    logic [3:0]  digit_reg [NDIGITS];
    logic        take;
    logic [7:0]  b;
    logic [2:0]  code;
    logic [3:0]  nib;
    logic [2:0]  cmd;

    // only a carriage return needs queue space
    assign b        = in_word.rx_byte;
    assign in_stall = frm_stall && !in_word.flush && (b == CH_CR);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        code = ST_OK;
        nib  = 4'd0;
        if (count_reg == 5'd0)
        begin
            if (b != CH_QUERY) code = ST_START;
        end
        else if (count_reg == 5'd1)
        begin
            code = ST_OK;
        end
        else if (count_reg < 5'd18)
        begin
            if (!is_digit(b) && b != CH_SP) code = ST_DATA;
        end
        else if (count_reg == 5'd18)
        begin
            if (b != CH_AT) code = ST_TAG;
        end
        else if (is_digit(b))
            nib = 4'(b - CH_0);
        else if (b >= CH_A && b <= CH_F)
            nib = 4'(b - CH_A + 8'd10);
        else
            code = ST_HEX;
    end

    assign cmd = (letter_reg >= CH_A && letter_reg <= CH_E) ? 3'(letter_reg - CH_A) : CMD_OTHER;

    always_comb
    begin
        frm_valid = in_valid && !in_word.flush && (b == CH_CR);
        frm.command = cmd;
        if (count_reg != FRAME_LEN)
            frm.status = ST_LENGTH;
        else if (err_reg != ST_OK)
            frm.status = err_reg;
        else if (crc_reg != hex_reg)
            frm.status = ST_CRC;
        else if (cmd == CMD_OTHER)
            frm.status = ST_UNKNOWN;
        else
            frm.status = ST_OK;
        frm.rcrc = (frm.status == ST_OK || frm.status == ST_CRC || frm.status == ST_UNKNOWN)
                   ? hex_reg : 16'd0;
        for (int i = 0; i < NDIGITS; i++)
            frm.digits[i*4 +: 4] = digit_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            crc_reg    <= '0;
            hex_reg    <= '0;
            err_reg    <= '0;
            letter_reg <= '0;
        end
        else if (take)
        begin
            if (in_word.flush || b == CH_CR)
            begin
                count_reg  <= '0;
                crc_reg    <= '0;
                hex_reg    <= '0;
                err_reg    <= '0;
                letter_reg <= '0;
            end
            else if (count_reg >= FRAME_LEN)
                count_reg <= OVER_LEN;
            else
            begin
                count_reg <= count_reg + 5'd1;
                if (code != ST_OK && (err_reg == ST_OK || code < err_reg))
                    err_reg <= code;
                if (count_reg < 5'd18)
                    crc_reg <= crc_byte(crc_reg, b);
                if (count_reg == 5'd1)
                    letter_reg <= b;
                if (count_reg > 5'd18)
                    hex_reg <= {hex_reg[11:0], nib};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !in_word.flush && b != CH_CR && count_reg >= 5'd2 && count_reg < 5'd14)
            digit_reg[4'(count_reg - 5'd2)] <= is_digit(b) ? 4'(b - CH_0) : 4'd0;
    end

`ifndef NO_ASSERTIONS
    a_sat: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= OVER_LEN)
        else $error("byte count beyond saturation");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (in_word.flush || b == CH_CR)) |=> (count_reg == 5'd0 && err_reg == ST_OK))
        else $error("frame state not cleared");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> frm_stall)
        else $error("input stalled without queue backpressure");
`endif

endmodule

>>> hdl/cfc_queue.sv
// Two-entry queue of frame summaries between front and back parts.
`timescale 1ns / 1ps
module cfc_queue
    import cfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  frame_t wr_data,
    input  logic   wr_valid,
    output logic   wr_stall,
    output frame_t rd_data,
    output logic   rd_valid,
    input  logic   rd_stall
);

    frame_t     mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wptr_reg != rptr_reg))
        else $error("queue pointers disagree with count");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid && rd_stall) |=> rd_valid)
        else $error("stalled entry lost");
`endif

endmodule

>>> hdl/cfc_back.sv
// Back part: decodes numeric groups, updates settings mask, drives output register.
`timescale 1ns / 1ps
module cfc_back
    import cfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  frame_t    frm,
    input  logic      frm_valid,
    output logic      frm_stall,
    output out_word_t out_word,
    output logic      out_valid,
    input  logic      out_stall
);

    logic [3:0] mask_reg;
    logic       take;
    out_word_t  res;
    logic [3:0] d [NDIGITS];
    logic [3:0] mask_or;
    logic [9:0] g3 [4];
    logic [6:0] g2 [6];

    assign frm_stall = out_valid && out_stall;
    assign take      = frm_valid && !frm_stall;

    always_comb
    begin
        for (int i = 0; i < NDIGITS; i++)
            d[i] = frm.digits[i*4 +: 4];
        for (int k = 0; k < 4; k++)
            g3[k] = 10'(d[3*k]) * 10'd100 + 10'(d[3*k+1]) * 10'd10 + 10'(d[3*k+2]);
        for (int k = 0; k < 6; k++)
            g2[k] = 7'(d[2*k]) * 7'd10 + 7'(d[2*k+1]);
        mask_or = mask_reg | (4'd1 << frm.command[1:0]);
        res = '0;
        res.frame_status = frm.status;
        res.command      = frm.command;
        res.received_crc = frm.rcrc;
        if (frm.status == ST_OK)
        begin
            if (frm.command == CMD_DATE)
            begin
                res.value_0 = {1'b0, g2[0]};
                res.value_1 = {1'b0, g2[1]};
                res.value_2 = {1'b0, g2[2]};
                res.value_3 = {1'b0, g2[3]};
                res.value_4 = g2[4];
                res.value_5 = g2[5];
            end
            else
            begin
                res.value_0 = g3[0][7:0];
                res.value_1 = g3[1][7:0];
                res.value_2 = g3[2][7:0];
                res.value_3 = g3[3][7:0];
                res.settings_complete = (frm.command == CMD_NTP) && (mask_or == 4'hF);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (take || !out_stall)
                out_valid <= take;
            if (take && frm.status == ST_OK && frm.command != CMD_DATE)
                mask_reg <= (frm.command == CMD_NTP) ? 4'd0 : mask_or;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) out_word <= res;
    end

`ifndef NO_ASSERTIONS
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.settings_complete) |=> (mask_reg == 4'd0))
        else $error("mask not cleared after completion");
    a_okonly: assert property (@(posedge clk) disable iff (!rst_n)
        (take && frm.status != ST_OK) |=> $stable(mask_reg))
        else $error("failed frame changed mask");
    a_cmplt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.settings_complete) |-> (out_word.command == CMD_NTP))
        else $error("completion flag on wrong command");
`endif

endmodule

>>> hdl/command_frame_checker_top.sv
// Top level of the command frame checker.
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_word  (rx_byte, flush)
//  output  | out_valid | out_stall | out_word (status, command, values, crc, complete)
// One byte per cycle unless stalled; a CR result passes the queue and the output register.
// The summary queue holds two frames; only a carriage return can stall input, when it is full.
// Reset is asynchronous and clears frame state and the settings mask.
`timescale 1ns / 1ps
module command_frame_checker_top
    import cfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  logic      in_valid,
    output logic      in_stall,
    output out_word_t out_word,
    output logic      out_valid,
    input  logic      out_stall
);

    frame_t f_frm, q_frm;
    logic   f_valid, f_stall, q_valid, q_stall;

    cfc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .frm(f_frm), .frm_valid(f_valid), .frm_stall(f_stall)
    );

    cfc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_frm), .wr_valid(f_valid),
        .wr_stall(f_stall), .rd_data(q_frm), .rd_valid(q_valid), .rd_stall(q_stall)
    );

    cfc_back u_back (
        .clk(clk), .rst_n(rst_n), .frm(q_frm), .frm_valid(q_valid), .frm_stall(q_stall),
        .out_word(out_word), .out_valid(out_valid), .out_stall(out_stall)
    );

endmodule
